>>> design/fwlrd_pkg.sv
// Shared types, constants and header decode for the firmware log record deframer.
`timescale 1ns / 1ps
`default_nettype none

package fwlrd_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned LEVEL_W   = 3;
  localparam int unsigned APP_W     = 5;
  localparam int unsigned ARGC_W    = 8;
  localparam int unsigned LINE_W    = 16;
  localparam int unsigned MODULE_W  = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(4);
  localparam logic [7:0]         MAX_APP   = 8'd15;
  localparam logic [APP_W-1:0]   APP_MGMT  = APP_W'(16);

  // Register map.
  localparam logic [CFG_ADDR_W-1:0] ADDR_EXPECTED_FORMAT = CFG_ADDR_W'(0);

  typedef enum logic [KIND_W-1:0] {
    KIND_DONE    = 2'd0,
    KIND_CORRUPT = 2'd1,
    KIND_TRUNC   = 2'd2
  } fwlrd_kind_t;

  typedef enum logic [1:0] {
    PH_TS  = 2'd0,
    PH_HDR = 2'd1,
    PH_PAY = 2'd2
  } fwlrd_phase_t;

  typedef struct packed {
    fwlrd_kind_t          kind;
    logic [WORD_W-1:0]    timestamp;
    logic [LEVEL_W-1:0]   level;
    logic [APP_W-1:0]     app_id;
    logic [ARGC_W-1:0]    arg_count;
    logic [LINE_W-1:0]    line_number;
    logic [MODULE_W-1:0]  module_id;
  } fwlrd_res_t;

  // Builds a result from a timestamp and a header word. Without a header,
  // all header-derived fields are zero.
  function automatic fwlrd_res_t fwlrd_make_res(fwlrd_kind_t kind,
                                                logic [WORD_W-1:0] ts,
                                                logic [WORD_W-1:0] hdr,
                                                logic use_hdr);
    fwlrd_res_t res;
    logic [7:0] app;
    app           = hdr[23:16];
    res.kind      = kind;
    res.timestamp = ts;
    res.level       = use_hdr ? hdr[10:8] : '0;
    res.app_id      = !use_hdr ? '0 : ((app > MAX_APP) ? APP_MGMT : app[APP_W-1:0]);
    res.arg_count   = use_hdr ? hdr[31:24] : '0;
    res.line_number = use_hdr ? hdr[47:32] : '0;
    res.module_id   = use_hdr ? hdr[63:48] : '0;
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/fwlrd_ifs.sv
// Valid/ready channel interfaces for log words in and deframed results out.
`timescale 1ns / 1ps
`default_nettype none

interface fwlrd_in_if import fwlrd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] log_word;
  logic              chunk_end;

  modport source(output valid, log_word, chunk_end, input ready);
  modport sink(input valid, log_word, chunk_end, output ready);
endinterface

interface fwlrd_out_if import fwlrd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [WORD_W-1:0]   timestamp;
  logic [LEVEL_W-1:0]  level;
  logic [APP_W-1:0]    app_id;
  logic [ARGC_W-1:0]   arg_count;
  logic [LINE_W-1:0]   line_number;
  logic [MODULE_W-1:0] module_id;

  modport source(output valid, kind, timestamp, level, app_id, arg_count, line_number,
                 module_id, input ready);
  modport sink(input valid, kind, timestamp, level, app_id, arg_count, line_number,
               module_id, output ready);
endinterface

`default_nettype wire

>>> design/fwlrd_parser.sv
// Record parsing state machine: phase, held words and payload word count.
`timescale 1ns / 1ps
`default_nettype none

module fwlrd_parser import fwlrd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              last,
  input  wire logic              expected_format,
  output logic                   res_valid,
  output fwlrd_res_t             res
);

  fwlrd_phase_t      phase_r, phase_nxt;
  logic [WORD_W-1:0] held_ts_r, held_ts_nxt;
  logic [WORD_W-1:0] held_hdr_r, held_hdr_nxt;
  logic [ARGC_W-1:0] left_r, left_nxt;

  logic [ARGC_W-1:0] argc;
  logic [ARGC_W:0]   argc_plus1;
  logic [ARGC_W-1:0] left_dec;
  logic              hdr_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TS;
      held_ts_r  <= '0;
      held_hdr_r <= '0;
      left_r     <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      held_ts_r  <= held_ts_nxt;
      held_hdr_r <= held_hdr_nxt;
      left_r     <= left_nxt;
    end
  end

  assign argc       = word[31:24];
  assign argc_plus1 = {1'b0, argc} + (ARGC_W+1)'(1);
  assign left_dec   = left_r - ARGC_W'(1);
  assign hdr_bad    = (word[0] != expected_format) || (argc == '0) ||
                      (word[10:8] > MAX_LEVEL);

  always_comb begin
    phase_nxt    = phase_r;
    held_ts_nxt  = held_ts_r;
    held_hdr_nxt = held_hdr_r;
    left_nxt     = left_r;
    res_valid    = 1'b0;
    res          = fwlrd_make_res(KIND_TRUNC, word, word, 1'b0);
    case (phase_r)
      PH_HDR: begin
        if (hdr_bad) begin
          // The rejected header is retried as the next timestamp.
          res_valid   = 1'b1;
          res         = fwlrd_make_res(KIND_CORRUPT, held_ts_r, word, 1'b1);
          held_ts_nxt = word;
          phase_nxt   = PH_HDR;
        end else begin
          held_hdr_nxt = word;
          left_nxt     = argc_plus1[ARGC_W:1];
          phase_nxt    = PH_PAY;
          res_valid    = last;
          res          = fwlrd_make_res(KIND_TRUNC, held_ts_r, word, 1'b1);
        end
      end
      PH_PAY: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          res_valid = 1'b1;
          res       = fwlrd_make_res(KIND_DONE, held_ts_r, held_hdr_r, 1'b1);
          phase_nxt = PH_TS;
        end else begin
          res_valid = last;
          res       = fwlrd_make_res(KIND_TRUNC, held_ts_r, held_hdr_r, 1'b1);
        end
      end
      default: begin
        held_ts_nxt = word;
        phase_nxt   = PH_HDR;
        res_valid   = last;
        res         = fwlrd_make_res(KIND_TRUNC, word, word, 1'b0);
      end
    endcase
    if (last) begin
      phase_nxt = PH_TS;
    end
  end

  a_trunc_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_TRUNC) |-> last)
    else $error("truncation reported on a word that does not end the chunk");

  a_done_from_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_DONE) |-> (phase_r == PH_PAY))
    else $error("complete record reported outside the payload phase");

  a_chunk_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && last) |=> (phase_r == PH_TS))
    else $error("phase did not return to timestamp after chunk end");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_r == PH_HDR && !hdr_bad && !last) |=> (left_r != '0))
    else $error("accepted header left an empty payload count");

endmodule

`default_nettype wire

>>> design/fw_log_record_deframer_top.sv
// Top level of the firmware log record deframer: channels, register port, stage registers.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one 64-bit log word per beat and walks the record
// framing: a timestamp word, a header word, then (argc + 1) / 2 payload
// words. It reports at most one result per input beat: a complete record
// when its last payload word arrives, a corrupt header when the format bit
// differs from the expected_format register, argc is zero or the level is
// above 4 (the rejected word is then reused as the next timestamp), or a
// truncation when chunk_end marks a word that leaves a record unfinished.
// Words are accepted back to back, one beat per cycle sustained; each word
// goes through one input register and the parse logic into one result
// register. The result register is loaded with the input register's result
// when the stage advances. The combinational header decode and payload
// counter set that rate. A full result register that is not taken stalls
// the input register, and the input side then drops ready. The
// expected_format register sits at byte address 0 of the configuration
// port, resets to 1 and should only be written while no beats are in
// flight.
module fw_log_record_deframer_top import fwlrd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fwlrd_in_if.sink                   in_bus,
  fwlrd_out_if.source                out_bus,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  // Configuration register.
  logic exp_fmt_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_fmt_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr == ADDR_EXPECTED_FORMAT) begin
      exp_fmt_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_EXPECTED_FORMAT) ?
                      {{(CFG_DATA_W-1){1'b0}}, exp_fmt_r} : '0;

  // Input register. It moves on whenever the result register can take
  // whatever this word produces.
  logic              in_valid_r;
  logic [WORD_W-1:0] in_word_r;
  logic              in_last_r;
  logic              advance;
  logic              in_take;

  logic              out_valid_r;
  fwlrd_res_t        out_res_r;
  logic              res_valid;
  fwlrd_res_t        res;

  assign advance      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_bus.log_word;
      in_last_r <= in_bus.chunk_end;
    end
  end

  fwlrd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .word            (in_word_r),
    .last            (in_last_r),
    .expected_format (exp_fmt_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.kind        = out_res_r.kind;
  assign out_bus.timestamp   = out_res_r.timestamp;
  assign out_bus.level       = out_res_r.level;
  assign out_bus.app_id      = out_res_r.app_id;
  assign out_bus.arg_count   = out_res_r.arg_count;
  assign out_bus.line_number = out_res_r.line_number;
  assign out_bus.module_id   = out_res_r.module_id;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !advance)
    else $error("stage advanced while a result was still waiting");

  a_stall_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_word_r) && $stable(in_last_r)))
    else $error("stalled input word was lost or changed");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("waiting result was dropped or changed");

endmodule

`default_nettype wire
